>>> hw/rtl/fmprc_pkg.sv
package fmprc_pkg;

    localparam int RULE_DEPTH_DEF = 64;

    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [7:0]  PROTO_ANY = 8'd143;
    localparam logic [15:0] PORT_WILD = 16'd0;
    localparam logic [15:0] PORT_HIGH = 16'd1023;
    localparam logic [1:0]  DIR_ANY   = 2'd3;
    localparam logic [1:0]  ACK_ANY   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_DIR  = 3'd1;
    localparam logic [2:0] ST_BAD_PFX  = 3'd2;
    localparam logic [2:0] ST_PORTS    = 3'd3;
    localparam logic [2:0] ST_BAD_ACK  = 3'd4;
    localparam logic [2:0] ST_ACK_NANY = 3'd5;

    localparam logic [1:0] RSN_MATCH = 2'd0;
    localparam logic [1:0] RSN_NONE  = 2'd1;
    localparam logic [1:0] RSN_XMAS  = 2'd2;

    // One stored rule, masks already expanded.
    typedef struct packed {
        logic [31:0] src_net;
        logic [31:0] src_mask;
        logic [31:0] dst_net;
        logic [31:0] dst_mask;
        logic [1:0]  dir;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack;
        logic        act;
    } rule_t;

    // Packet header travelling along the chain.
    typedef struct packed {
        logic [1:0]  dir;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack;
    } pkt_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic live;
        logic found;
        logic drop;
    } tok_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++)
        begin
            m[31 - b] = (6'(b) < len);
        end
        return m;
    endfunction

    function automatic logic port_hits(input logic [15:0] pkt, input logic [15:0] rule);
        return (rule == PORT_WILD) || (rule == pkt) || ((rule == PORT_HIGH) && (pkt > 16'd1023));
    endfunction

endpackage

>>> hw/rtl/fmprc_cell.sv
// One rule slot: holds the rule and compares the header seen this cycle.
module fmprc_cell (
    input  logic                 clk,
    input  logic                 wr_en,
    input  fmprc_pkg::rule_t     wr_rule,
    input  fmprc_pkg::pkt_t      pkt,
    input  logic                 active,
    input  fmprc_pkg::tok_t      tok_in,
    output fmprc_pkg::tok_t      tok_out
);

    fmprc_pkg::rule_t rule_reg;
    logic hit;

    // Rule storage; written only by a valid rule write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_reg <= wr_rule;
        end
    end

    // Match logic for this slot.
    always_comb
    begin
        hit = 1'b1;
        if (rule_reg.dir != fmprc_pkg::DIR_ANY && rule_reg.dir != pkt.dir)
            hit = 1'b0;
        if ((pkt.src & rule_reg.src_mask) != (rule_reg.src_net & rule_reg.src_mask))
            hit = 1'b0;
        if ((pkt.dst & rule_reg.dst_mask) != (rule_reg.dst_net & rule_reg.dst_mask))
            hit = 1'b0;
        if (rule_reg.proto != fmprc_pkg::PROTO_ANY && rule_reg.proto != pkt.proto)
            hit = 1'b0;
        if (pkt.proto == fmprc_pkg::PROTO_TCP || pkt.proto == fmprc_pkg::PROTO_UDP)
        begin
            if (!fmprc_pkg::port_hits(pkt.sport, rule_reg.sport))
                hit = 1'b0;
            if (!fmprc_pkg::port_hits(pkt.dport, rule_reg.dport))
                hit = 1'b0;
            if (pkt.proto == fmprc_pkg::PROTO_TCP && rule_reg.ack != fmprc_pkg::ACK_ANY
                && rule_reg.ack != pkt.ack)
                hit = 1'b0;
        end
    end

    // Pass the token on, claiming it on the first hit.
    always_comb
    begin
        tok_out = tok_in;
        if (tok_in.live && !tok_in.found && active && hit)
        begin
            tok_out.found = 1'b1;
            tok_out.drop  = rule_reg.act;
        end
    end

endmodule

>>> hw/rtl/first_match_packet_rule_classifier_unit.sv
// Channel | direction | handshake
// in      | input     | in_valid / in_stall
// out     | output    | out_valid / out_stall
// cfg     | input     | cfg_wr_en / cfg_wr_data
//
// Writes and non-IPv4 or Xmas classifies load the output register at the accepting
// edge; the next item is not taken until that result has drained.
// A full classify walks the cell chain one group of 8 cells per cycle and stops at the
// first group with a hit or after the last group; the done state then loads the
// output register, so a classify is finished before the next item is taken.
// Reset clears the control state and rule_count; rule entries stay undefined.
// The output register holds while out_stall is high; input waits until it drains.
module first_match_packet_rule_classifier_unit #(
    parameter int RULE_DEPTH = fmprc_pkg::RULE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [5:0]  rule_slot,
    input  logic [1:0]  direction,
    input  logic [31:0] src_address,
    input  logic [5:0]  src_prefix_len,
    input  logic [31:0] dst_address,
    input  logic [5:0]  dst_prefix_len,
    input  logic [7:0]  protocol,
    input  logic [15:0] src_l4_port,
    input  logic [15:0] dst_l4_port,
    input  logic [1:0]  ack_value,
    input  logic [2:0]  flag_bits,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        verdict_drop,
    output logic [1:0]  reason_kind,
    output logic [5:0]  hit_index,
    output logic [2:0]  write_status
);

    localparam int GRP = 8;
    localparam int NGRP = (RULE_DEPTH + GRP - 1) / GRP;
    localparam int GW = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int CW = $clog2(RULE_DEPTH + 1);
    localparam int NCELL = NGRP * GRP;

    fmprc_pkg::state_t state_reg, state_next;
    logic [6:0]    count_reg;
    fmprc_pkg::pkt_t pkt_reg;
    logic [GW-1:0] grp_reg, grp_next;
    logic          found_reg, drop_reg;
    logic [5:0]    idx_reg;
    logic          accept, out_fire;
    logic          ov_reg, ov_next;
    logic          vd_reg;
    logic [1:0]    rk_reg;
    logic [5:0]    hi_reg;
    logic [2:0]    ws_reg;
    logic          res_ld;
    logic          res_vd;
    logic [1:0]    res_rk;
    logic [5:0]    res_hi;
    logic [2:0]    res_ws;
    logic [2:0]    wstat;
    logic          last_grp;
    fmprc_pkg::rule_t wr_rule;
    fmprc_pkg::tok_t tok [NCELL+1];
    logic [NCELL-1:0] cell_we, cell_sel, cell_act;
    logic [CW-1:0] lim;
    logic          g_found, g_drop;
    logic [2:0]    g_off;

    assign accept   = in_valid && !in_stall;
    assign out_fire = ov_reg && !out_stall;
    assign in_stall = (state_reg != fmprc_pkg::S_IDLE) || ov_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_wr_en)
            count_reg <= cfg_wr_data;
    end

    assign lim = (32'(count_reg) > RULE_DEPTH) ? CW'(RULE_DEPTH) : CW'(count_reg);

    // Rule write checks in status order.
    always_comb
    begin
        priority if (direction == 2'd0)
            wstat = fmprc_pkg::ST_BAD_DIR;
        else if (src_prefix_len > 6'd32 || dst_prefix_len > 6'd32)
            wstat = fmprc_pkg::ST_BAD_PFX;
        else if (protocol != fmprc_pkg::PROTO_TCP && protocol != fmprc_pkg::PROTO_UDP
                 && (src_l4_port != fmprc_pkg::PORT_WILD
                     || dst_l4_port != fmprc_pkg::PORT_WILD))
            wstat = fmprc_pkg::ST_PORTS;
        else if (ack_value == 2'd0)
            wstat = fmprc_pkg::ST_BAD_ACK;
        else if (protocol != fmprc_pkg::PROTO_TCP && ack_value != fmprc_pkg::ACK_ANY)
            wstat = fmprc_pkg::ST_ACK_NANY;
        else
            wstat = fmprc_pkg::ST_OK;
    end

    assign wr_rule = '{src_net: src_address, src_mask: fmprc_pkg::prefix_mask(src_prefix_len),
                       dst_net: dst_address, dst_mask: fmprc_pkg::prefix_mask(dst_prefix_len),
                       dir: direction, proto: protocol, sport: src_l4_port,
                       dport: dst_l4_port, ack: ack_value, act: flag_bits[0]};

    // Cell chain: only the group under the counter is live each cycle.
    assign tok[0] = '{live: 1'b0, found: 1'b0, drop: 1'b0};
    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        fmprc_pkg::tok_t t_in;
        assign cell_we[c]  = accept && op && (wstat == fmprc_pkg::ST_OK)
                             && (32'(rule_slot) == c) && (c < RULE_DEPTH);
        assign cell_sel[c] = (32'(grp_reg) == c / GRP);
        assign cell_act[c] = (c < RULE_DEPTH) && (CW'(c) < lim);
        always_comb
        begin
            t_in = tok[c];
            if (c % GRP == 0)
                t_in = '{live: cell_sel[c], found: 1'b0, drop: 1'b0};
        end
        fmprc_cell u_cell (
            .clk    (clk),
            .wr_en  (cell_we[c]),
            .wr_rule(wr_rule),
            .pkt    (pkt_reg),
            .active (cell_act[c]),
            .tok_in (t_in),
            .tok_out(tok[c+1])
        );
    end

    // Pick the result of the live group and its first hit offset.
    always_comb
    begin
        g_found = 1'b0;
        g_drop  = 1'b0;
        g_off   = '0;
        for (int c = NCELL - 1; c >= 0; c--)
        begin
            if (cell_sel[c] && tok[c+1].found && !tok[c].found
                && (c % GRP == 0 || tok[c].live))
            begin
                g_found = 1'b1;
                g_drop  = tok[c+1].drop;
                g_off   = 3'(c % GRP);
            end
        end
        for (int c = 0; c < NCELL; c++)
        begin
            if (c % GRP == GRP - 1 && cell_sel[c])
            begin
                g_found = tok[c+1].found;
                g_drop  = tok[c+1].drop;
            end
        end
    end

    assign last_grp = (32'(grp_reg) == NGRP - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmprc_pkg::S_IDLE:
                if (accept && !op && flag_bits[1] && !flag_bits[2])
                    state_next = fmprc_pkg::S_RUN;
            fmprc_pkg::S_RUN:
                if (g_found || last_grp)
                    state_next = fmprc_pkg::S_DONE;
            fmprc_pkg::S_DONE:
                state_next = fmprc_pkg::S_IDLE;
            default:
                state_next = fmprc_pkg::S_IDLE;
        endcase
    end

    // Result loading.
    always_comb
    begin
        res_ld = 1'b0;
        res_vd = 1'b0;
        res_rk = fmprc_pkg::RSN_MATCH;
        res_hi = '0;
        res_ws = fmprc_pkg::ST_OK;
        grp_next = grp_reg;
        unique case (state_reg)
            fmprc_pkg::S_IDLE:
            begin
                grp_next = '0;
                if (accept)
                begin
                    if (op)
                    begin
                        res_ld = 1'b1;
                        res_ws = wstat;
                    end
                    else if (!flag_bits[1])
                    begin
                        res_ld = 1'b1;
                        res_rk = fmprc_pkg::RSN_NONE;
                    end
                    else if (flag_bits[2])
                    begin
                        res_ld = 1'b1;
                        res_vd = 1'b1;
                        res_rk = fmprc_pkg::RSN_XMAS;
                    end
                end
            end
            fmprc_pkg::S_RUN:
                grp_next = grp_reg + GW'(1);
            fmprc_pkg::S_DONE:
            begin
                res_ld = 1'b1;
                res_vd = found_reg && drop_reg;
                res_rk = found_reg ? fmprc_pkg::RSN_MATCH : fmprc_pkg::RSN_NONE;
                res_hi = found_reg ? idx_reg : 6'd0;
            end
            default: ;
        endcase
        ov_next = res_ld ? 1'b1 : (out_fire ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmprc_pkg::S_IDLE;
            ov_reg    <= 1'b0;
            grp_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            grp_reg   <= grp_next;
            if (state_reg == fmprc_pkg::S_IDLE)
                found_reg <= 1'b0;
            else if (state_reg == fmprc_pkg::S_RUN && g_found)
                found_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            pkt_reg <= '{dir: direction, src: src_address, dst: dst_address, proto: protocol,
                         sport: src_l4_port, dport: dst_l4_port, ack: ack_value};
        if (state_reg == fmprc_pkg::S_RUN && g_found)
        begin
            drop_reg <= g_drop;
            idx_reg  <= 6'({grp_reg, g_off});
        end
        if (res_ld)
        begin
            vd_reg <= res_vd;
            rk_reg <= res_rk;
            hi_reg <= res_hi;
            ws_reg <= res_ws;
        end
    end

    assign out_valid    = ov_reg;
    assign verdict_drop = vd_reg;
    assign reason_kind  = rk_reg;
    assign hit_index    = hi_reg;
    assign write_status = ws_reg;

    // Checks.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != fmprc_pkg::S_IDLE) |-> !accept) else $error("accept while busy");
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmprc_pkg::S_DONE) |=> out_valid) else $error("result lost");
    a_found_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmprc_pkg::S_RUN && g_found) |=> (state_reg == fmprc_pkg::S_DONE))
        else $error("search ran past a hit");

endmodule
